/* rtl/colp2p_pkg.sv */
// Shared constants and types for the column peak-to-peak block.
// No dependencies; imported by every module of the block.
`default_nettype none

package colp2p_pkg;

	localparam int COLUMNS             = 8;
	localparam int SAMPLE_BITS_DEFAULT = 16;
	localparam int ROW_BITS            = 8;
	localparam int COUNT_BITS          = 4;
	localparam int P2P_BITS            = 16;
	localparam int OUT_COL_BITS        = 3;
	localparam int QUEUE_DEPTH         = 2;

	localparam int COL_BITS    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int ACTIVE_BITS = $clog2(COLUMNS + 1);

	localparam logic [ROW_BITS-1:0]   ROW_LIMIT   = '1;
	localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(8);

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

`default_nettype wire

/* rtl/colp2p_front.sv */
// Front end: accepts rows, tracks per-column extremes and their rows. On a
// last row, queues one block summary unless count is 0. Uses colp2p_pkg.
`default_nettype none

module colp2p_front
	import colp2p_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
	input  wire                                      clk,
	input  wire                                      arst_n,
	input  wire                                      in_valid,
	output logic                                     in_stall,
	input  wire  [COLUMNS-1:0][SAMPLE_BITS-1:0]      samples,
	input  wire                                      last_row,
	input  wire  [COUNT_BITS-1:0]                    column_count,
	input  wire  q_status_t                          q_status,
	output logic                                     push,
	output logic [COLUMNS-1:0][SAMPLE_BITS-1:0]      push_max,
	output logic [COLUMNS-1:0][SAMPLE_BITS-1:0]      push_min,
	output logic [COLUMNS-1:0][ROW_BITS-1:0]         push_max_row,
	output logic [COLUMNS-1:0][ROW_BITS-1:0]         push_min_row,
	output logic [ACTIVE_BITS-1:0]                   push_active
);

	logic [ROW_BITS-1:0]                 row_q;
	logic [COLUMNS-1:0][SAMPLE_BITS-1:0] max_q, min_q;
	logic [COLUMNS-1:0][ROW_BITS-1:0]    max_row_q, min_row_q;
	logic                                first;
	logic                                accept;

	// only a closing row needs a queue slot
	assign in_stall = q_status.full && last_row;
	assign accept   = in_valid && !in_stall;
	assign first    = (row_q == '0);

	always_comb begin
		for (int c = 0; c < COLUMNS; c++) begin
			if (first) begin
				push_max[c]     = samples[c];
				push_min[c]     = samples[c];
				push_max_row[c] = '0;
				push_min_row[c] = '0;
			end else begin
				push_max[c]     = max_q[c];
				push_min[c]     = min_q[c];
				push_max_row[c] = max_row_q[c];
				push_min_row[c] = min_row_q[c];
				if (samples[c] > max_q[c]) begin
					push_max[c]     = samples[c];
					push_max_row[c] = row_q;
				end
				if (samples[c] < min_q[c]) begin
					push_min[c]     = samples[c];
					push_min_row[c] = row_q;
				end
			end
		end
	end

	always_comb begin
		if (column_count > COUNT_BITS'(COLUMNS)) begin
			push_active = ACTIVE_BITS'(COLUMNS);
		end else begin
			push_active = ACTIVE_BITS'(column_count);
		end
	end

	// a zero column count closes the block without a summary
	assign push = accept && last_row && (push_active != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (accept) begin
			if (last_row) begin
				row_q <= '0;
			end else if (row_q != ROW_LIMIT) begin
				row_q <= row_q + ROW_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			max_q     <= push_max;
			min_q     <= push_min;
			max_row_q <= push_max_row;
			min_row_q <= push_min_row;
		end
	end

endmodule

`default_nettype wire

/* rtl/colp2p_queue.sv */
// Short queue of block summaries between front and back end.
// Register entries, one write and one read pointer. Uses colp2p_pkg.
`default_nettype none

module colp2p_queue
	import colp2p_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 push,
	input  wire  [COLUMNS-1:0][SAMPLE_BITS-1:0] wr_max,
	input  wire  [COLUMNS-1:0][SAMPLE_BITS-1:0] wr_min,
	input  wire  [COLUMNS-1:0][ROW_BITS-1:0]    wr_max_row,
	input  wire  [COLUMNS-1:0][ROW_BITS-1:0]    wr_min_row,
	input  wire  [ACTIVE_BITS-1:0]              wr_active,
	input  wire                                 pop,
	output q_status_t                           q_status,
	output logic [COLUMNS-1:0][SAMPLE_BITS-1:0] rd_max,
	output logic [COLUMNS-1:0][SAMPLE_BITS-1:0] rd_min,
	output logic [COLUMNS-1:0][ROW_BITS-1:0]    rd_max_row,
	output logic [COLUMNS-1:0][ROW_BITS-1:0]    rd_min_row,
	output logic [ACTIVE_BITS-1:0]              rd_active
);

	localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	logic [COLUMNS-1:0][SAMPLE_BITS-1:0] max_q     [QUEUE_DEPTH];
	logic [COLUMNS-1:0][SAMPLE_BITS-1:0] min_q     [QUEUE_DEPTH];
	logic [COLUMNS-1:0][ROW_BITS-1:0]    max_row_q [QUEUE_DEPTH];
	logic [COLUMNS-1:0][ROW_BITS-1:0]    min_row_q [QUEUE_DEPTH];
	logic [ACTIVE_BITS-1:0]              active_q  [QUEUE_DEPTH];

	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0] cnt_q;

	assign q_status.full  = (cnt_q == CNT_BITS'(QUEUE_DEPTH));
	assign q_status.empty = (cnt_q == '0);

	assign rd_max     = max_q[rd_ptr_q];
	assign rd_min     = min_q[rd_ptr_q];
	assign rd_max_row = max_row_q[rd_ptr_q];
	assign rd_min_row = min_row_q[rd_ptr_q];
	assign rd_active  = active_q[rd_ptr_q];

	function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] p);
		if (p == PTR_BITS'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + PTR_BITS'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_BITS'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			max_q[wr_ptr_q]     <= wr_max;
			min_q[wr_ptr_q]     <= wr_min;
			max_row_q[wr_ptr_q] <= wr_max_row;
			min_row_q[wr_ptr_q] <= wr_min_row;
			active_q[wr_ptr_q]  <= wr_active;
		end
	end

endmodule

`default_nettype wire

/* rtl/colp2p_back.sv */
// Back end: unless stalled, walks the head summary one column per cycle
// into the output reg; pops at last active column. Uses colp2p_pkg.
`default_nettype none

module colp2p_back
	import colp2p_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire  q_status_t                     q_status,
	input  wire  [COLUMNS-1:0][SAMPLE_BITS-1:0] rd_max,
	input  wire  [COLUMNS-1:0][SAMPLE_BITS-1:0] rd_min,
	input  wire  [COLUMNS-1:0][ROW_BITS-1:0]    rd_max_row,
	input  wire  [COLUMNS-1:0][ROW_BITS-1:0]    rd_min_row,
	input  wire  [ACTIVE_BITS-1:0]              rd_active,
	output logic                                pop,
	output logic                                out_valid,
	input  wire                                 out_stall,
	output logic [OUT_COL_BITS-1:0]             column_index,
	output logic [P2P_BITS-1:0]                 peak_to_peak,
	output logic [ROW_BITS-1:0]                 max_row,
	output logic [ROW_BITS-1:0]                 min_row,
	output logic                                last_result
);

	logic [COL_BITS-1:0]    col_q;
	logic                   out_valid_q;
	logic [OUT_COL_BITS-1:0] col_out_q;
	logic [P2P_BITS-1:0]    p2p_q;
	logic [ROW_BITS-1:0]    max_row_q, min_row_q;
	logic                   last_q;

	logic                   load;
	logic                   is_last;
	logic [SAMPLE_BITS-1:0] diff;

	assign load    = !q_status.empty && (!out_valid_q || !out_stall);
	assign is_last = (ACTIVE_BITS'(col_q) + ACTIVE_BITS'(1) == rd_active);
	assign pop     = load && is_last;
	assign diff    = rd_max[col_q] - rd_min[col_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				col_q       <= is_last ? '0 : col_q + COL_BITS'(1);
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			col_out_q <= OUT_COL_BITS'(col_q);
			p2p_q     <= P2P_BITS'(diff);
			max_row_q <= rd_max_row[col_q];
			min_row_q <= rd_min_row[col_q];
			last_q    <= is_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign column_index = col_out_q;
	assign peak_to_peak = p2p_q;
	assign max_row      = max_row_q;
	assign min_row      = min_row_q;
	assign last_result  = last_q;

endmodule

`default_nettype wire

/* rtl/column_peak_to_peak.sv */
// Column peak-to-peak detector, top level: config register, front end,
// summary queue and back end. Uses colp2p_pkg, colp2p_front/queue/back.
//
// Usage:
//  - Input channel (in_valid / in_stall): one row of eight samples and
//    last_row per transfer, one row per cycle unless in_stall is high.
//    in_stall rises only for a last row while both queue slots are taken.
//  - Output channel (out_valid / out_stall): after a last row, one result
//    per active column, column 0 first, last_result on the final one.
//    The block summary is queued, then the back end moves it to the output
//    register column by column, one result per cycle unless stalled.
//  - Config (cfg_valid / cfg_ready): cfg_data sets column_count, always
//    ready; write it only while the block is idle. Counts above eight act
//    as eight; a count of zero closes the block without results.
//  - Reset: the next row starts a new block, column_count is 8, the queue
//    and the output register are empty.
//  - A stalled output holds its result; the front end keeps taking rows
//    while the queue has room, so the next block can be tracked meanwhile.
`default_nettype none

module column_peak_to_peak
	import colp2p_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_stall,
	input  wire  [SAMPLE_BITS-1:0]  sample_0,
	input  wire  [SAMPLE_BITS-1:0]  sample_1,
	input  wire  [SAMPLE_BITS-1:0]  sample_2,
	input  wire  [SAMPLE_BITS-1:0]  sample_3,
	input  wire  [SAMPLE_BITS-1:0]  sample_4,
	input  wire  [SAMPLE_BITS-1:0]  sample_5,
	input  wire  [SAMPLE_BITS-1:0]  sample_6,
	input  wire  [SAMPLE_BITS-1:0]  sample_7,
	input  wire                     last_row,
	input  wire                     cfg_valid,
	output logic                    cfg_ready,
	input  wire  [COUNT_BITS-1:0]   cfg_data,
	output logic                    out_valid,
	input  wire                     out_stall,
	output logic [OUT_COL_BITS-1:0] column_index,
	output logic [P2P_BITS-1:0]     peak_to_peak,
	output logic [ROW_BITS-1:0]     max_row,
	output logic [ROW_BITS-1:0]     min_row,
	output logic                    last_result
);

	logic [COUNT_BITS-1:0]               count_q;
	logic [COLUMNS-1:0][SAMPLE_BITS-1:0] samples;
	q_status_t                           q_status;

	logic                                push, pop;
	logic [COLUMNS-1:0][SAMPLE_BITS-1:0] push_max, push_min, rd_max, rd_min;
	logic [COLUMNS-1:0][ROW_BITS-1:0]    push_max_row, push_min_row;
	logic [COLUMNS-1:0][ROW_BITS-1:0]    rd_max_row, rd_min_row;
	logic [ACTIVE_BITS-1:0]              push_active, rd_active;

	assign samples[0] = sample_0;
	assign samples[1] = sample_1;
	assign samples[2] = sample_2;
	assign samples[3] = sample_3;
	assign samples[4] = sample_4;
	assign samples[5] = sample_5;
	assign samples[6] = sample_6;
	assign samples[7] = sample_7;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			count_q <= cfg_data;
		end
	end

	colp2p_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.samples      (samples),
		.last_row     (last_row),
		.column_count (count_q),
		.q_status     (q_status),
		.push         (push),
		.push_max     (push_max),
		.push_min     (push_min),
		.push_max_row (push_max_row),
		.push_min_row (push_min_row),
		.push_active  (push_active)
	);

	colp2p_queue #(.SAMPLE_BITS(SAMPLE_BITS)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_max     (push_max),
		.wr_min     (push_min),
		.wr_max_row (push_max_row),
		.wr_min_row (push_min_row),
		.wr_active  (push_active),
		.pop        (pop),
		.q_status   (q_status),
		.rd_max     (rd_max),
		.rd_min     (rd_min),
		.rd_max_row (rd_max_row),
		.rd_min_row (rd_min_row),
		.rd_active  (rd_active)
	);

	colp2p_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_status     (q_status),
		.rd_max       (rd_max),
		.rd_min       (rd_min),
		.rd_max_row   (rd_max_row),
		.rd_min_row   (rd_min_row),
		.rd_active    (rd_active),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.column_index (column_index),
		.peak_to_peak (peak_to_peak),
		.max_row      (max_row),
		.min_row      (min_row),
		.last_result  (last_result)
	);

	// summary never written into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_status.full))
		else $error("summary pushed into full queue");

	// nothing popped from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && q_status.empty))
		else $error("summary popped from empty queue");

	// within a burst, results follow back to back in column order
	a_burst_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_result |=>
			out_valid && (column_index == $past(column_index) + OUT_COL_BITS'(1)))
		else $error("burst result missing or out of order");

	// a burst after a final result starts again at column zero
	a_burst_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_result |=>
			!out_valid || (column_index == '0))
		else $error("new burst does not start at column zero");

endmodule

`default_nettype wire
